// File: rtl/core/ctpsc_pkg.sv
// Types, constants and the control store of the crank timer period setter.
package ctpsc_pkg;

	localparam int FREQ_W   = 16;
	localparam int CLK_W    = 28;
	localparam int LIM_W    = 16;
	localparam int EDGE_W   = 8;
	localparam int RELOAD_W = 16;
	localparam int PSC_W    = 7;
	localparam int CFG_W    = 28;
	localparam int CFG_IDX_W = 2;

	// Divider: 28-bit dividend, 24-bit divisor (frequency times edges).
	localparam int DIVD_W = CLK_W;
	localparam int DIVS_W = FREQ_W + EDGE_W;
	localparam int CNT_W  = 5;
	localparam int PHI_W  = DIVD_W - RELOAD_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGES       = 2'd3;

	localparam logic [CLK_W-1:0]  RST_CLOCK_HZ    = 28'd72000000;
	localparam logic [LIM_W-1:0]  RST_LOWER_LIMIT = 16'd10;
	localparam logic [LIM_W-1:0]  RST_UPPER_LIMIT = 16'd8000;
	localparam logic [EDGE_W-1:0] RST_EDGES       = 8'd6;

	// Datapath operations
	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_DECIDE = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_DIV1   = 3'd3;
	localparam logic [2:0] OP_STEP   = 3'd4;
	localparam logic [2:0] OP_PSC    = 3'd5;
	localparam logic [2:0] OP_DIV2   = 3'd6;
	localparam logic [2:0] OP_LOAD   = 3'd7;

	// Sequencing conditions
	localparam logic [2:0] C_NEXT     = 3'd0;
	localparam logic [2:0] C_WAIT_IN  = 3'd1;
	localparam logic [2:0] C_DECIDE   = 3'd2;
	localparam logic [2:0] C_LOOP     = 3'd3;
	localparam logic [2:0] C_WAIT_OUT = 3'd4;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] S_DECIDE = 4'd1;
	localparam logic [STEP_W-1:0] S_MUL    = 4'd2;
	localparam logic [STEP_W-1:0] S_DIV1   = 4'd3;
	localparam logic [STEP_W-1:0] S_STEP1  = 4'd4;
	localparam logic [STEP_W-1:0] S_PSC    = 4'd5;
	localparam logic [STEP_W-1:0] S_DIV2   = 4'd6;
	localparam logic [STEP_W-1:0] S_STEP2  = 4'd7;
	localparam logic [STEP_W-1:0] S_LOAD   = 4'd8;

	typedef struct packed {
		logic              in_rdy;
		logic [2:0]        op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctrl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			S_IDLE:   w = '{1'b1, OP_NOP,    C_WAIT_IN,  S_IDLE};
			S_DECIDE: w = '{1'b0, OP_DECIDE, C_DECIDE,   S_IDLE};
			S_MUL:    w = '{1'b0, OP_MUL,    C_NEXT,     S_IDLE};
			S_DIV1:   w = '{1'b0, OP_DIV1,   C_NEXT,     S_IDLE};
			S_STEP1:  w = '{1'b0, OP_STEP,   C_LOOP,     S_IDLE};
			S_PSC:    w = '{1'b0, OP_PSC,    C_NEXT,     S_IDLE};
			S_DIV2:   w = '{1'b0, OP_DIV2,   C_NEXT,     S_IDLE};
			S_STEP2:  w = '{1'b0, OP_STEP,   C_LOOP,     S_IDLE};
			S_LOAD:   w = '{1'b0, OP_LOAD,   C_WAIT_OUT, S_IDLE};
			default:  w = '{1'b0, OP_NOP,    C_WAIT_OUT, S_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/ctpsc_if.sv
// Request and result channel interfaces of the crank timer period setter.
interface ctpsc_req_if;
	import ctpsc_pkg::*;
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency;
	modport source (output valid, output frequency, input ready);
	modport sink   (input valid, input frequency, output ready);
endinterface

interface ctpsc_res_if;
	import ctpsc_pkg::*;
	logic                valid;
	logic                ready;
	logic                timer_on;
	logic                start_event;
	logic                load;
	logic [RELOAD_W-1:0] reload_value;
	logic [PSC_W-1:0]    prescaler_value;
	modport source (output valid, output timer_on, output start_event, output load,
		output reload_value, output prescaler_value, input ready);
	modport sink   (input valid, input timer_on, input start_event, input load,
		input reload_value, input prescaler_value, output ready);
endinterface

// File: rtl/core/ctpsc_div.sv
// Restoring divider, one quotient bit per cycle while ctrl.step is asserted.
module ctpsc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctpsc_pkg::div_ctrl_t        ctrl,
	input  logic [ctpsc_pkg::DIVD_W-1:0] dividend,
	input  logic [ctpsc_pkg::DIVS_W-1:0] divisor,
	output logic [ctpsc_pkg::DIVD_W-1:0] quotient,
	output logic                        last
);
	import ctpsc_pkg::*;

	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [DIVD_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W:0]   trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign last  = cnt_q == CNT_W'(DIVD_W - 1);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= '0;
		end else if (ctrl.step && !last) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (ctrl.step) begin
			// trial stays below twice the divisor, so the difference fits
			rem_q <= ge ? DIVS_W'(trial - {1'b0, dsr_q}) : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end
endmodule

// File: rtl/core/crank_timer_period_setter_core.sv
// Top level of the crank timer period setter: sequencer, datapath and registers.
//
// A request carries a crank signal frequency; each request gives exactly one
// result with timer_on, start_event, load, reload_value and prescaler_value.
// Requests move on valid/ready; one request is worked on at a time.
// At or below the lower limit the timer is reported stopped; the first request
// above it only reports a start; later requests below the upper limit load a
// new period. For a load, the period is clock_hz / (frequency * edges), found
// by a restoring divider, the prescaler is the period's upper bits clipped to
// MAX_PRESCALE_STEPS, and the reload value comes from a second pass of the
// same divider. The shared divider sets the rate. Results sit in an output
// register: the next request is taken while a result waits, and the sequencer
// holds before writing a new one until it is taken. Reset loads the register
// defaults and clears the started flag; registers are written through cfg_we,
// cfg_index and cfg_data. The user must write them only while the block is
// idle; the block itself does not enforce this.
module crank_timer_period_setter_core #(
	parameter int MAX_PRESCALE_STEPS = 100
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ctpsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctpsc_pkg::CFG_W-1:0]   cfg_data,
	ctpsc_req_if.sink                     req,
	ctpsc_res_if.source                   res
);
	import ctpsc_pkg::*;

	localparam int PS_W = $clog2(MAX_PRESCALE_STEPS + 1);

	logic [CLK_W-1:0]  clock_q;
	logic [LIM_W-1:0]  lower_q;
	logic [LIM_W-1:0]  upper_q;
	logic [EDGE_W-1:0] edges_q;
	logic              started_q;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	ucode_t            uw;

	logic [FREQ_W-1:0] freq_q;
	logic [DIVS_W-1:0] prod_q;
	logic [PS_W-1:0]   psc_q;
	logic [PS_W-1:0]   psc_d;
	logic [PHI_W-1:0]  period_hi;
	logic [EDGE_W-1:0] edges_eff;

	logic                out_valid_q;
	logic                on_q;
	logic                start_q;
	logic                load_q;
	logic [RELOAD_W-1:0] reload_q;
	logic [PSC_W-1:0]    pscout_q;

	logic slot_free;
	logic in_fire;
	logic below_lo;
	logic compute;
	logic res_wr;

	div_ctrl_t         div_ctrl;
	logic [DIVD_W-1:0] div_dividend;
	logic [DIVS_W-1:0] div_divisor;
	logic [DIVD_W-1:0] div_quo;
	logic              div_last;

	assign uw        = ucode_rom(step_q);
	assign req.ready = uw.in_rdy;
	assign in_fire   = req.valid && uw.in_rdy;
	assign slot_free = !out_valid_q || res.ready;
	assign below_lo  = freq_q <= lower_q;
	assign compute   = !below_lo && started_q && (freq_q < upper_q);
	assign edges_eff = (edges_q == '0) ? EDGE_W'(1) : edges_q;
	assign period_hi = div_quo[DIVD_W-1:RELOAD_W];
	assign psc_d     = (period_hi > PHI_W'(MAX_PRESCALE_STEPS)) ?
		PS_W'(MAX_PRESCALE_STEPS) : PS_W'(period_hi);
	assign res_wr    = slot_free && ((uw.op == OP_DECIDE && !compute) || uw.op == OP_LOAD);

	// Sequencer
	always_comb begin
		step_d = step_q;
		case (uw.cond)
			C_NEXT:     step_d = step_q + STEP_W'(1);
			C_WAIT_IN:  if (in_fire) step_d = step_q + STEP_W'(1);
			C_DECIDE: begin
				if (slot_free) step_d = compute ? step_q + STEP_W'(1) : uw.target;
			end
			C_LOOP:     if (div_last) step_d = step_q + STEP_W'(1);
			C_WAIT_OUT: if (slot_free) step_d = uw.target;
			default:    step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= RST_CLOCK_HZ;
			lower_q <= RST_LOWER_LIMIT;
			upper_q <= RST_UPPER_LIMIT;
			edges_q <= RST_EDGES;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_HZ:    clock_q <= cfg_data[CLK_W-1:0];
				CFG_LOWER_LIMIT: lower_q <= cfg_data[LIM_W-1:0];
				CFG_UPPER_LIMIT: upper_q <= cfg_data[LIM_W-1:0];
				CFG_EDGES:       edges_q <= cfg_data[EDGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Started flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (uw.op == OP_DECIDE && slot_free) begin
			started_q <= !below_lo;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_fire) freq_q <= req.frequency;
		if (uw.op == OP_MUL) prod_q <= DIVS_W'(freq_q) * DIVS_W'(edges_eff);
		if (uw.op == OP_PSC) psc_q <= psc_d;
	end

	always_comb begin
		div_ctrl.start = (uw.op == OP_DIV1) || (uw.op == OP_DIV2);
		div_ctrl.step  = uw.op == OP_STEP;
		// second pass divides the period, still held in the divider
		div_dividend   = (uw.op == OP_DIV2) ? div_quo : clock_q;
		div_divisor    = (uw.op == OP_DIV2) ? DIVS_W'(psc_q) + DIVS_W'(1) : prod_q;
	end

	ctpsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.last     (div_last)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_wr) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			if (uw.op == OP_LOAD) begin
				on_q     <= 1'b1;
				start_q  <= 1'b0;
				load_q   <= 1'b1;
				reload_q <= div_quo[RELOAD_W-1:0];
				pscout_q <= PSC_W'(psc_q);
			end else begin
				on_q     <= !below_lo;
				start_q  <= !below_lo && !started_q;
				load_q   <= 1'b0;
				reload_q <= '0;
				pscout_q <= '0;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.timer_on        = on_q;
	assign res.start_event     = start_q;
	assign res.load            = load_q;
	assign res.reload_value    = reload_q;
	assign res.prescaler_value = pscout_q;

	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.load |-> res.timer_on)
		else $error("load reported with timer stopped");

	a_start_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.start_event |-> res.timer_on && !res.load)
		else $error("start result loads or reports timer stopped");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_PSC |-> $past(div_last))
		else $error("prescaler taken before period division finished");

endmodule

// File: tb/tb_crank_timer_period_setter_core.sv
// Self-checking testbench of the crank timer period setter core.
`timescale 1ns / 100ps

module tb_crank_timer_period_setter_core;
	import ctpsc_pkg::*;

	localparam int MAX_PRESCALE_STEPS = 100;

	typedef struct packed {
		logic                timer_on;
		logic                start_event;
		logic                load;
		logic [RELOAD_W-1:0] reload_value;
		logic [PSC_W-1:0]    prescaler_value;
	} timer_setting_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ctpsc_req_if req_ch ();
	ctpsc_res_if res_ch ();

	crank_timer_period_setter_core #(
		.MAX_PRESCALE_STEPS(MAX_PRESCALE_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.res      (res_ch)
	);

	always #4 clk = ~clk;

	// Shadow of the block's registers and started flag
	logic [CLK_W-1:0]  clock_hz   = RST_CLOCK_HZ;
	logic [LIM_W-1:0]  lower_lim  = RST_LOWER_LIMIT;
	logic [LIM_W-1:0]  upper_lim  = RST_UPPER_LIMIT;
	logic [EDGE_W-1:0] edge_count = RST_EDGES;
	logic              timer_running = 1'b0;

	logic [FREQ_W-1:0] pending_freqs[$];
	timer_setting_t    expected_settings[$];
	int                mismatch_count = 0;
	int                sender_idle_pct = 0;
	int                receiver_stall_pct = 0;

	function automatic timer_setting_t next_timer_setting(input logic [FREQ_W-1:0] freq);
		timer_setting_t s;
		logic [31:0]    edges;
		logic [31:0]    divisor;
		logic [31:0]    period;
		logic [31:0]    quotient;
		logic [31:0]    psc;
		int             n;
		s = '0;
		if (freq > lower_lim) begin
			if (!timer_running) begin
				timer_running = 1'b1;
				s.start_event = 1'b1;
			end else if (freq < upper_lim) begin
				// zero edges counts as one
				edges    = (edge_count == '0) ? 32'd1 : 32'(edge_count);
				divisor  = 32'(freq) * edges;
				period   = (divisor == 32'd0) ? 32'd0 : 32'(clock_hz) / divisor;
				psc      = 32'd0;
				quotient = period;
				for (n = 0; n < MAX_PRESCALE_STEPS && quotient > 32'd65535; n++) begin
					psc      = psc + 32'd1;
					quotient = period / (psc + 32'd1);
				end
				s.load            = 1'b1;
				s.reload_value    = RELOAD_W'(period / (psc + 32'd1));
				s.prescaler_value = PSC_W'(psc);
			end
		end else begin
			timer_running = 1'b0;
		end
		s.timer_on = timer_running;
		return s;
	endfunction

	function automatic logic [FREQ_W-1:0] pick_frequency();
		int r;
		int lo;
		int hi;
		r  = $urandom_range(0, 99);
		lo = int'(lower_lim) + 1;
		hi = int'(upper_lim) - 1;
		if (r < 12)
			return FREQ_W'($urandom_range(0, int'(lower_lim)));
		else if (r < 22)
			return FREQ_W'($urandom);
		else if (r < 30 && upper_lim != '0)
			return FREQ_W'($urandom_range(int'(upper_lim), 65535));
		else if (hi >= lo) begin
			// low frequencies give long periods and push the prescaler
			if (r < 50)
				return FREQ_W'($urandom_range(lo, (lo + 63 < hi) ? lo + 63 : hi));
			return FREQ_W'($urandom_range(lo, hi));
		end
		return FREQ_W'($urandom);
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CLOCK_HZ:    clock_hz   = value[CLK_W-1:0];
			CFG_LOWER_LIMIT: lower_lim  = value[LIM_W-1:0];
			CFG_UPPER_LIMIT: upper_lim  = value[LIM_W-1:0];
			CFG_EDGES:       edge_count = value[EDGE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int clk_hz, input int lo, input int hi, input int edges);
		write_register(CFG_CLOCK_HZ, CFG_W'(clk_hz));
		write_register(CFG_LOWER_LIMIT, CFG_W'(lo));
		write_register(CFG_UPPER_LIMIT, CFG_W'(hi));
		write_register(CFG_EDGES, CFG_W'(edges));
	endtask

	task automatic wait_drained();
		// sample between edges, once the driver and monitor have settled
		do
			@(negedge clk);
		while (pending_freqs.size() != 0 || req_ch.valid || expected_settings.size() != 0);
		// let the sequencer settle back to idle
		repeat (4) @(posedge clk);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.frequency <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_settings.push_back(next_timer_setting(req_ch.frequency));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_freqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req_ch.valid     <= 1'b1;
					req_ch.frequency <= pending_freqs.pop_front();
				end else begin
					req_ch.valid     <= 1'b0;
					req_ch.frequency <= FREQ_W'($urandom);
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		timer_setting_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_settings.size() == 0) begin
					$error("result with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_settings.pop_front();
					if (res_ch.timer_on !== want.timer_on) begin
						$error("timer_on: expected %0d, got %0d", want.timer_on, res_ch.timer_on);
						mismatch_count++;
					end
					if (res_ch.start_event !== want.start_event) begin
						$error("start_event: expected %0d, got %0d",
							want.start_event, res_ch.start_event);
						mismatch_count++;
					end
					if (res_ch.load !== want.load) begin
						$error("load: expected %0d, got %0d", want.load, res_ch.load);
						mismatch_count++;
					end
					if (res_ch.reload_value !== want.reload_value) begin
						$error("reload_value: expected %0d, got %0d",
							want.reload_value, res_ch.reload_value);
						mismatch_count++;
					end
					if (res_ch.prescaler_value !== want.prescaler_value) begin
						$error("prescaler_value: expected %0d, got %0d",
							want.prescaler_value, res_ch.prescaler_value);
						mismatch_count++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int ph;
		int i;
		int lo;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: stop, first start above the upper limit, hold, loads, restart
		pending_freqs = '{16'd0, 16'd65535, 16'd65535, 16'd11, 16'd7999, 16'd8000,
			16'd10, 16'd11, 16'd11, 16'd1, 16'd5000, 16'd12};
		wait_drained();

		// fastest clock, one edge: prescaler runs out on the lowest frequency
		apply_setting(200000000, 0, 65535, 1);
		pending_freqs = '{16'd0, 16'd1, 16'd1, 16'd65534, 16'd3};
		wait_drained();

		// zero clock and zero edges
		apply_setting(0, 0, 65535, 0);
		pending_freqs = '{16'd7, 16'd7, 16'd65534};
		wait_drained();

		// widest clock, upper limit below lower: hold, hold, stop
		apply_setting(268435455, 65534, 0, 255);
		pending_freqs = '{16'd65535, 16'd65535, 16'd65534};
		wait_drained();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_setting(int'(RST_CLOCK_HZ), int'(RST_LOWER_LIMIT),
					int'(RST_UPPER_LIMIT), int'(RST_EDGES));
				1: apply_setting(200000000, 0, 65535, 1);
				2: apply_setting($urandom_range(1, 1000), $urandom_range(0, 20), 65535, 0);
				default: begin
					lo = $urandom_range(0, 2000);
					apply_setting($urandom_range(0, 268435455), lo,
						$urandom_range(lo, 65535), $urandom_range(0, 255));
				end
			endcase
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
				default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
			endcase
			for (i = 0; i < 60; i++)
				pending_freqs.push_back(pick_frequency());
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
